@@ hw/rtl/fgsu_pkg.sv @@
// Shared types, codes and helpers for the fused gate state update unit.
package fgsu_pkg;

    localparam int AMP_W   = 32;
    localparam int PHASE_W = 16;
    localparam int QUBIT_W = 6;
    localparam int PROD_W  = AMP_W + PHASE_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int FRAC_SH = 14;

    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_PROCESS = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        OP_X      = 3'd0,
        OP_Y      = 3'd1,
        OP_Z      = 3'd2,
        OP_PHASE  = 3'd3,
        OP_CPHASE = 3'd4,
        OP_CX     = 3'd5,
        OP_CZ     = 3'd6,
        OP_CCX    = 3'd7
    } op_code_t;

    // Accumulator action of the shared multiply unit
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2,
        ACC_ADD  = 2'd3
    } acc_op_t;

    typedef struct packed {
        op_code_t                    op;
        logic [QUBIT_W-1:0]          tgt;
        logic [QUBIT_W-1:0]          c0;
        logic [QUBIT_W-1:0]          c1;
        logic signed [PHASE_W-1:0]   pr;
        logic signed [PHASE_W-1:0]   pi;
    } op_entry_t;

    // Negate with the minimum value clamped to the maximum
    function automatic logic signed [AMP_W-1:0] neg_sat(input logic signed [AMP_W-1:0] v);
        logic signed [AMP_W-1:0] r;
        if (v == AMP_MIN)
        begin
            r = AMP_MAX;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fgsu_if.sv @@
// Request and response channel interfaces of the fused gate state update unit.
interface fgsu_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [2:0]         op_code;
    logic [5:0]         target_bit;
    logic [5:0]         first_control;
    logic [5:0]         second_control;
    logic signed [15:0] phase_real;
    logic signed [15:0] phase_imag;
    logic [63:0]        basis_state;
    logic signed [31:0] amp_real;
    logic signed [31:0] amp_imag;

    modport source (
        output valid, req_type, op_code, target_bit, first_control, second_control,
               phase_real, phase_imag, basis_state, amp_real, amp_imag,
        input  ready
    );

    modport sink (
        input  valid, req_type, op_code, target_bit, first_control, second_control,
               phase_real, phase_imag, basis_state, amp_real, amp_imag,
        output ready
    );
endinterface

interface fgsu_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        new_state;
    logic signed [31:0] new_real;
    logic signed [31:0] new_imag;
    logic               table_overflow;

    modport source (
        output valid, new_state, new_real, new_imag, table_overflow,
        input  ready
    );

    modport sink (
        input  valid, new_state, new_real, new_imag, table_overflow,
        output ready
    );
endinterface

@@ hw/rtl/fgsu_mac.sv @@
// Shared multiply-accumulate unit with Q2.14 rounding and 32-bit saturation.
module fgsu_mac (
    input  logic                   clk,
    input  logic signed [31:0]     mul_a,
    input  logic signed [15:0]     mul_b,
    input  fgsu_pkg::acc_op_t      acc_op,
    output logic signed [31:0]     result
);
    import fgsu_pkg::*;

    localparam int RND_W = ACC_W + 1;
    localparam int SH_W  = RND_W - FRAC_SH;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [RND_W-1:0]  rounded;
    logic signed [SH_W-1:0]   shifted;

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {prod_reg[PROD_W-1], prod_reg};

    always_comb
    begin
        case (acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Round half up, drop the fraction, then clamp
    assign rounded = {acc_reg[ACC_W-1], acc_reg} + RND_W'(1 << (FRAC_SH - 1));
    assign shifted = rounded[RND_W-1:FRAC_SH];

    always_comb
    begin
        if (&shifted[SH_W-1:AMP_W-1] || ~|shifted[SH_W-1:AMP_W-1])
        begin
            result = shifted[AMP_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            result = AMP_MIN;
        end
        else
        begin
            result = AMP_MAX;
        end
    end

endmodule

@@ hw/rtl/fused_gate_state_update_unit.sv @@
// Top level of the fused gate state update unit: operation table, sequencer, output register.
// Append and clear beats complete in the idle state. A process beat walks the stored operation
// table in order, one operation per cycle from a single registered table read port, except
// that a phase or controlled phase operation whose qubits are set holds the walk for its
// multiply steps on the one shared 32x16 multiply-accumulate unit. The request side is ready
// again on the cycle the result turns valid, and it is not ready during the walk. While an
// earlier result still waits on rsp.ready, the finished walk holds until it drains. The
// result is held in an output register, and append and clear beats are taken while it waits.
// The table holds MAX_OPS entries; entries read only below the fill count need no clearing.
module fused_gate_state_update_unit #(
    parameter int MAX_OPS    = 32,
    parameter int STATE_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    fgsu_req_if.sink   req,
    fgsu_rsp_if.source rsp
);
    import fgsu_pkg::*;

    localparam int CNT_W = $clog2(MAX_OPS + 1);
    localparam int IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

    typedef enum logic [5:0] {
        MS_IDLE = 6'b000001,
        MS_IMPI = 6'b000010,
        MS_REPI = 6'b000100,
        MS_IMPR = 6'b001000,
        MS_SUMI = 6'b010000,
        MS_DONE = 6'b100000
    } mstep_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    mstep_t                  mstep_reg, mstep_next;
    logic                    out_valid_reg, out_valid_next;

    logic [STATE_BITS-1:0]   s_reg, s_next;
    logic signed [31:0]      re_reg, re_next;
    logic signed [31:0]      im_reg, im_next;
    logic signed [31:0]      tmp_re_reg, tmp_re_next;
    logic [63:0]             out_state_reg;
    logic signed [31:0]      out_re_reg;
    logic signed [31:0]      out_im_reg;
    logic                    out_ovf_reg;

    op_entry_t               op_mem [MAX_OPS];
    op_entry_t               rd_entry_reg;
    op_entry_t               wr_entry;
    logic                    tbl_we;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    logic signed [31:0]      mul_a;
    logic signed [15:0]      mul_b;
    acc_op_t                 acc_op;
    logic signed [31:0]      mac_result;

    logic [63:0]             s64;
    logic [STATE_BITS-1:0]   s_flip;
    logic [63:0]             s_flip64;
    logic                    tbit;
    logic                    c0bit;
    logic                    c1bit;
    logic                    y_bit;
    logic                    last_op;
    logic [CNT_W-1:0]        idx_inc;
    logic                    advance;
    logic                    out_load;
    logic                    req_fire;

    fgsu_mac u_mac (
        .clk    (clk),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .acc_op (acc_op),
        .result (mac_result)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign wr_entry.op  = op_code_t'(req.op_code);
    assign wr_entry.tgt = req.target_bit;
    assign wr_entry.c0  = req.first_control;
    assign wr_entry.c1  = req.second_control;
    assign wr_entry.pr  = req.phase_real;
    assign wr_entry.pi  = req.phase_imag;

    // Qubits at or above STATE_BITS read as zero and never flip
    assign s64      = 64'(s_reg);
    assign s_flip   = s_reg ^ STATE_BITS'(64'd1 << rd_entry_reg.tgt);
    assign s_flip64 = 64'(s_flip);
    assign tbit     = s64[rd_entry_reg.tgt];
    assign c0bit    = s64[rd_entry_reg.c0];
    assign c1bit    = s64[rd_entry_reg.c1];
    assign y_bit    = s_flip64[rd_entry_reg.tgt];
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign last_op  = (idx_inc == count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        mstep_next  = mstep_reg;
        s_next      = s_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        tmp_re_next = tmp_re_reg;
        tbl_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        mul_a       = re_reg;
        mul_b       = rd_entry_reg.pr;
        acc_op      = ACC_HOLD;
        advance     = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg == CNT_W'(MAX_OPS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                tbl_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_PROCESS:
                        begin
                            s_next   = STATE_BITS'(req.basis_state);
                            re_next  = req.amp_real;
                            im_next  = req.amp_imag;
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_EXEC;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_EXEC:
            begin
                // First product of a phase op is launched here
                case (rd_entry_reg.op)
                    OP_X:
                    begin
                        s_next  = s_flip;
                        advance = 1'b1;
                    end
                    OP_Y:
                    begin
                        s_next = s_flip;
                        if (y_bit)
                        begin
                            re_next = neg_sat(im_reg);
                            im_next = re_reg;
                        end
                        else
                        begin
                            re_next = im_reg;
                            im_next = neg_sat(re_reg);
                        end
                        advance = 1'b1;
                    end
                    OP_Z:
                    begin
                        if (tbit)
                        begin
                            re_next = neg_sat(re_reg);
                            im_next = neg_sat(im_reg);
                        end
                        advance = 1'b1;
                    end
                    OP_PHASE:
                    begin
                        if (tbit)
                        begin
                            mstep_next = MS_IMPI;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    OP_CPHASE:
                    begin
                        if (c0bit && tbit)
                        begin
                            mstep_next = MS_IMPI;
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    OP_CX:
                    begin
                        if (c0bit)
                        begin
                            s_next = s_flip;
                        end
                        advance = 1'b1;
                    end
                    OP_CZ:
                    begin
                        if (c0bit && tbit)
                        begin
                            re_next = neg_sat(re_reg);
                            im_next = neg_sat(im_reg);
                        end
                        advance = 1'b1;
                    end
                    OP_CCX:
                    begin
                        if (c0bit && c1bit)
                        begin
                            s_next = s_flip;
                        end
                        advance = 1'b1;
                    end
                    default:
                    begin
                        advance = 1'b1;
                    end
                endcase
            end

            ST_MUL:
            begin
                case (mstep_reg)
                    MS_IMPI:
                    begin
                        mul_a      = im_reg;
                        mul_b      = rd_entry_reg.pi;
                        acc_op     = ACC_LOAD;
                        mstep_next = MS_REPI;
                    end
                    MS_REPI:
                    begin
                        mul_a      = re_reg;
                        mul_b      = rd_entry_reg.pi;
                        acc_op     = ACC_SUB;
                        mstep_next = MS_IMPR;
                    end
                    MS_IMPR:
                    begin
                        // Hold the real part until the imaginary one is done
                        mul_a       = im_reg;
                        mul_b       = rd_entry_reg.pr;
                        tmp_re_next = mac_result;
                        acc_op      = ACC_LOAD;
                        mstep_next  = MS_SUMI;
                    end
                    MS_SUMI:
                    begin
                        acc_op     = ACC_ADD;
                        mstep_next = MS_DONE;
                    end
                    default:
                    begin
                        re_next    = tmp_re_reg;
                        im_next    = mac_result;
                        mstep_next = MS_IDLE;
                        advance    = 1'b1;
                    end
                endcase
            end

            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next table entry, prefetching it, or finish the walk after the last one
        if (advance)
        begin
            if (last_op)
            begin
                state_next = ST_OUT;
            end
            else
            begin
                idx_next   = idx_inc;
                rd_en      = 1'b1;
                rd_addr    = idx_inc[IDX_W-1:0];
                state_next = ST_EXEC;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            mstep_reg     <= MS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        tmp_re_reg <= tmp_re_next;
        if (out_load)
        begin
            out_state_reg <= 64'(s_reg);
            out_re_reg    <= re_reg;
            out_im_reg    <= im_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Operation table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            op_mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= op_mem[rd_addr];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.new_state      = out_state_reg;
    assign rsp.new_real       = out_re_reg;
    assign rsp.new_imag       = out_im_reg;
    assign rsp.table_overflow = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_OPS))
        else $error("operation count beyond table depth");

    a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC || state_reg == ST_MUL) |-> (idx_reg < count_reg))
        else $error("walk index outside filled table");

    a_full_append_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.req_type == REQ_APPEND && count_reg == CNT_W'(MAX_OPS))
        |=> (ovf_reg && $stable(count_reg)))
        else $error("append to full table not flagged or not dropped");

    a_mstep_only_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (mstep_reg == MS_IDLE))
        else $error("multiply step left active outside multiply phase");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && !rsp.ready) |=> (state_reg == ST_OUT))
        else $error("finished result overwrote a pending beat");

endmodule

@@ tb/sv/fused_gate_state_update_unit_tb.sv @@
// Self-checking testbench for the fused gate state update unit: gate table predictor and scoreboard.
module fused_gate_state_update_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fgsu_pkg::*;

    localparam int MAX_OPS      = 32;
    localparam int STATE_BITS   = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 450;

    typedef struct packed {
        req_type_t                 kind;
        op_code_t                  op;
        logic [QUBIT_W-1:0]        tgt;
        logic [QUBIT_W-1:0]        c0;
        logic [QUBIT_W-1:0]        c1;
        logic signed [PHASE_W-1:0] pr;
        logic signed [PHASE_W-1:0] pi;
        logic [63:0]               basis;
        logic signed [AMP_W-1:0]   ar;
        logic signed [AMP_W-1:0]   ai;
    } gate_req_t;

    typedef struct packed {
        logic [63:0]             state;
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
        logic                    ovf;
    } amp_update_t;

    class gate_table_scoreboard;
        op_entry_t   ops[MAX_OPS];
        int unsigned n_ops;
        bit          ovf;
        amp_update_t expected_q[$];
        int          errors;

        function new();
            n_ops  = 0;
            ovf    = 1'b0;
            errors = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint negate_clamped(longint v);
            return clamp32(-v);
        endfunction

        // Drop 14 fraction bits, round half up
        function longint round_q14(longint v);
            return clamp32((v + 64'sd8192) >>> 14);
        endfunction

        function bit qubit(logic [63:0] s, logic [QUBIT_W-1:0] idx);
            return (idx < STATE_BITS) ? s[idx] : 1'b0;
        endfunction

        function logic [63:0] flip(logic [63:0] s, logic [QUBIT_W-1:0] idx);
            if (idx < STATE_BITS)
            begin
                s[idx] = ~s[idx];
            end
            return s;
        endfunction

        function amp_update_t run_table(logic [63:0] basis, logic signed [AMP_W-1:0] ar,
                                        logic signed [AMP_W-1:0] ai);
            logic [63:0] s;
            longint      re;
            longint      im;
            longint      tmp;
            longint      pr;
            longint      pi;
            op_entry_t   e;
            amp_update_t r;
            int          k;
            s  = basis & ({64{1'b1}} >> (64 - STATE_BITS));
            re = ar;
            im = ai;
            for (k = 0; k < int'(n_ops); k++)
            begin
                e  = ops[k];
                pr = e.pr;
                pi = e.pi;
                case (e.op)
                    OP_X:
                    begin
                        s = flip(s, e.tgt);
                    end
                    OP_Y:
                    begin
                        s   = flip(s, e.tgt);
                        tmp = re;
                        if (qubit(s, e.tgt))
                        begin
                            re = negate_clamped(im);
                            im = tmp;
                        end
                        else
                        begin
                            re = im;
                            im = negate_clamped(tmp);
                        end
                    end
                    OP_Z, OP_CZ:
                    begin
                        if (qubit(s, e.tgt) && (e.op == OP_Z || qubit(s, e.c0)))
                        begin
                            re = negate_clamped(re);
                            im = negate_clamped(im);
                        end
                    end
                    OP_PHASE, OP_CPHASE:
                    begin
                        if (qubit(s, e.tgt) && (e.op == OP_PHASE || qubit(s, e.c0)))
                        begin
                            tmp = round_q14(re * pr - im * pi);
                            im  = round_q14(re * pi + im * pr);
                            re  = tmp;
                        end
                    end
                    OP_CX:
                    begin
                        if (qubit(s, e.c0))
                        begin
                            s = flip(s, e.tgt);
                        end
                    end
                    default:
                    begin
                        if (qubit(s, e.c0) && qubit(s, e.c1))
                        begin
                            s = flip(s, e.tgt);
                        end
                    end
                endcase
            end
            r.state = s;
            r.re    = re[AMP_W-1:0];
            r.im    = im[AMP_W-1:0];
            r.ovf   = ovf;
            return r;
        endfunction

        function void note_request(gate_req_t it);
            case (it.kind)
                REQ_APPEND:
                begin
                    if (n_ops >= MAX_OPS)
                    begin
                        ovf = 1'b1;
                    end
                    else
                    begin
                        ops[n_ops] = '{it.op, it.tgt, it.c0, it.c1, it.pr, it.pi};
                        n_ops++;
                    end
                end
                REQ_CLEAR:
                begin
                    n_ops = 0;
                    ovf   = 1'b0;
                end
                REQ_PROCESS:
                begin
                    expected_q.insert(expected_q.size(), run_table(it.basis, it.ar, it.ai));
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(amp_update_t got);
            amp_update_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat: new_state %h", got.state);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.state !== want.state)
            begin
                $error("new_state: expected %h, got %h", want.state, got.state);
                errors++;
            end
            if (got.re !== want.re)
            begin
                $error("new_real: expected %0d, got %0d", want.re, got.re);
                errors++;
            end
            if (got.im !== want.im)
            begin
                $error("new_imag: expected %0d, got %0d", want.im, got.im);
                errors++;
            end
            if (got.ovf !== want.ovf)
            begin
                $error("table_overflow: expected %b, got %b", want.ovf, got.ovf);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    fgsu_req_if req_ch();
    fgsu_rsp_if rsp_ch();

    fused_gate_state_update_unit #(
        .MAX_OPS    (MAX_OPS),
        .STATE_BITS (STATE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    gate_table_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_rsp       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic gate_req_t noise_item(req_type_t kind);
        gate_req_t it;
        it.kind  = kind;
        it.op    = op_code_t'($urandom_range(7));
        it.tgt   = QUBIT_W'($urandom);
        it.c0    = QUBIT_W'($urandom);
        it.c1    = QUBIT_W'($urandom);
        it.pr    = PHASE_W'($urandom);
        it.pi    = PHASE_W'($urandom);
        it.basis = {$urandom, $urandom};
        it.ar    = $urandom;
        it.ai    = $urandom;
        return it;
    endfunction

    function automatic gate_req_t gate_item(op_code_t op, logic [QUBIT_W-1:0] tgt,
                                            logic [QUBIT_W-1:0] c0, logic [QUBIT_W-1:0] c1,
                                            logic signed [PHASE_W-1:0] pr,
                                            logic signed [PHASE_W-1:0] pi);
        gate_req_t it;
        it     = noise_item(REQ_APPEND);
        it.op  = op;
        it.tgt = tgt;
        it.c0  = c0;
        it.c1  = c1;
        it.pr  = pr;
        it.pi  = pi;
        return it;
    endfunction

    function automatic gate_req_t state_item(logic [63:0] basis, logic signed [AMP_W-1:0] ar,
                                             logic signed [AMP_W-1:0] ai);
        gate_req_t it;
        it       = noise_item(REQ_PROCESS);
        it.basis = basis;
        it.ar    = ar;
        it.ai    = ai;
        return it;
    endfunction

    // Favor low qubits so controls and targets hit the same bits often
    function automatic logic [QUBIT_W-1:0] pick_qubit();
        return ($urandom_range(3) == 0) ? QUBIT_W'($urandom_range(63))
                                        : QUBIT_W'($urandom_range(7));
    endfunction

    function automatic logic signed [AMP_W-1:0] pick_amp();
        case ($urandom_range(7))
            0:       return AMP_MAX;
            1:       return AMP_MIN;
            2:       return 32'sh4000_0000;
            3:       return 32'shC000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic gate_req_t random_gate();
        logic signed [PHASE_W-1:0] pr;
        logic signed [PHASE_W-1:0] pi;
        case ($urandom_range(7))
            0:
            begin
                pr = 16'sd16384;
                pi = 16'sd0;
            end
            1:
            begin
                pr = 16'sd0;
                pi = 16'sd16384;
            end
            2:
            begin
                pr = 16'sd11585;
                pi = 16'sd11585;
            end
            3:
            begin
                pr = 16'shC000;
                pi = 16'sd0;
            end
            4:
            begin
                pr = 16'sh7FFF;
                pi = 16'sh8000;
            end
            default:
            begin
                pr = PHASE_W'($urandom);
                pi = PHASE_W'($urandom);
            end
        endcase
        return gate_item(op_code_t'($urandom_range(7)), pick_qubit(), pick_qubit(),
                         pick_qubit(), pr, pi);
    endfunction

    function automatic gate_req_t random_state();
        logic [63:0] basis;
        case ($urandom_range(7))
            0:       basis = '0;
            1:       basis = '1;
            default: basis = {$urandom, $urandom};
        endcase
        return state_item(basis, pick_amp(), pick_amp());
    endfunction

    task automatic drive_payload(input gate_req_t it);
        req_ch.req_type       <= it.kind;
        req_ch.op_code        <= it.op;
        req_ch.target_bit     <= it.tgt;
        req_ch.first_control  <= it.c0;
        req_ch.second_control <= it.c1;
        req_ch.phase_real     <= it.pr;
        req_ch.phase_imag     <= it.pi;
        req_ch.basis_state    <= it.basis;
        req_ch.amp_real       <= it.ar;
        req_ch.amp_imag       <= it.ai;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(input gate_req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        drive_payload(it);
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_request(it);
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(state_item('1, AMP_MIN, AMP_MAX));
        send_item(noise_item(REQ_NONE));
        // negate the most negative amplitude
        send_item(gate_item(OP_Z, 6'd0, 6'd0, 6'd0, 16'sd0, 16'sd0));
        send_item(state_item(64'd1, AMP_MIN, AMP_MIN));
        send_item(noise_item(REQ_CLEAR));
        send_item(gate_item(OP_X, 6'd63, 6'd0, 6'd0, 16'sd0, 16'sd0));
        send_item(gate_item(OP_Y, 6'd0, 6'd63, 6'd63, 16'sd0, 16'sd0));
        send_item(gate_item(OP_PHASE, 6'd2, 6'd0, 6'd0, 16'sh8000, 16'sh7FFF));
        send_item(gate_item(OP_CPHASE, 6'd3, 6'd63, 6'd0, 16'sh7FFF, 16'sh8000));
        send_item(gate_item(OP_CX, 6'd4, 6'd0, 6'd0, 16'sd0, 16'sd0));
        send_item(gate_item(OP_CZ, 6'd5, 6'd4, 6'd0, 16'sd0, 16'sd0));
        send_item(gate_item(OP_CCX, 6'd6, 6'd0, 6'd63, 16'sd0, 16'sd0));
        send_item(gate_item(OP_PHASE, 6'd7, 6'd0, 6'd0, 16'sd11585, 16'sd11585));
        send_item(state_item('1, AMP_MIN, AMP_MIN));
        send_item(state_item('0, AMP_MAX, 32'sd0));
        send_item(state_item(64'h8000_0000_0000_00FD, 32'sh4000_0000, 32'shC000_0000));
        send_item(random_state());
        send_item(noise_item(REQ_CLEAR));
        send_item(state_item('1, AMP_MAX, AMP_MAX));
    endtask

    // Mostly clear, fill, then process; a little noise in between
    task automatic run_random(input int quota);
        int sent;
        int n_app;
        int n_proc;
        int r;
        sent = 0;
        while (sent < quota)
        begin
            r = $urandom_range(99);
            if (r < 85)
            begin
                if (r < 72)
                begin
                    send_item(noise_item(REQ_CLEAR));
                    sent++;
                end
                n_app  = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(10);
                n_proc = $urandom_range(4, 1);
                repeat (n_app)
                begin
                    send_item(random_gate());
                    sent++;
                end
                repeat (n_proc)
                begin
                    send_item(random_state());
                    sent++;
                end
            end
            else if (r < 90)
            begin
                send_item(noise_item(REQ_NONE));
            end
            else if (r < 95)
            begin
                send_item(noise_item(REQ_PROCESS));
                sent++;
            end
            else
            begin
                send_item(noise_item(REQ_APPEND));
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                board.check_result('{rsp_ch.new_state, rsp_ch.new_real, rsp_ch.new_imag,
                                     rsp_ch.table_overflow});
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("fused_gate_state_update_unit_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        gate_req_t blank;
        blank = '0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        drive_payload(blank);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // hold results back while requests keep coming so the input stalls
        hold_rsp = 1'b1;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 55;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 55;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(PHASE_ITEMS);

        req_ch.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
        begin
            $display("fused_gate_state_update_unit_tb OK");
        end
        else
        begin
            $display("fused_gate_state_update_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
